// ----- rtl/ipv4dq_pkg.sv -----
// ----------------------------------------------------------------------------
// ipv4dq_pkg
// Shared types and character constants for the dotted-quad address parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv4dq_pkg;

  // input word: one character plus end-of-string flag
  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } in_word_t;

  // result word: well-formed flag and parsed address
  typedef struct packed {
    logic        valid_res;
    logic [31:0] address;
  } out_word_t;

  // parser state carried from one character to the next
  typedef struct packed {
    logic [11:0] octet_value;
    logic        have_digit;
    logic [1:0]  octet_count;
    logic [23:0] partial_address;
    logic        text_started;
    logic        in_trailing_space;
    logic        error_seen;
  } parse_state_t;

  // character codes
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_DOT   = 8'd46;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;

  // octet limits
  localparam logic [11:0] OCTET_MAX        = 12'd255;
  localparam logic [11:0] OCTET_VALUE_MAX  = 12'd2559;
  localparam logic [1:0]  LAST_OCTET_INDEX = 2'd3;

endpackage

`default_nettype wire

// ----- rtl/ipv4dq_in_stage.sv -----
// ----------------------------------------------------------------------------
// ipv4dq_in_stage
// Input register: holds one character word until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4dq_in_stage (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  ipv4dq_pkg::in_word_t  in_word_i,
  input  wire                   take_i,
  output logic                  held_valid_o,
  output ipv4dq_pkg::in_word_t  held_word_o
);
  import ipv4dq_pkg::*;

  logic     valid_q, valid_d;
  in_word_t word_q, word_d;
  logic     accept;

  // stall only while a held word is not taken this cycle
  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  // next register contents
  always_comb begin
    valid_d = valid_q;
    word_d  = word_q;
    if (accept) begin
      valid_d = 1'b1;
      word_d  = in_word_i;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign held_valid_o = valid_q;
  assign held_word_o  = word_q;

endmodule

`default_nettype wire

// ----- rtl/ipv4dq_core.sv -----
// ----------------------------------------------------------------------------
// ipv4dq_core
// Parser state and per-character update; forms the result on the last char.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4dq_core (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    fire_i,
  input  ipv4dq_pkg::in_word_t   word_i,
  output logic                   res_valid_o,
  output ipv4dq_pkg::out_word_t  res_word_o
);
  import ipv4dq_pkg::*;

  parse_state_t st_q, st_d, nx;
  logic [7:0]   c;
  logic         is_space, is_digit, is_dot;
  logic [3:0]   digit;
  logic [4:0]   byte_pos;
  logic         ok;

  assign c        = word_i.char_code;
  assign is_space = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
  assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  assign is_dot   = (c == CHAR_DOT);
  assign digit    = 4'(c - CHAR_ZERO);
  assign byte_pos = {st_q.octet_count, 3'b000};

  // state after taking this character
  always_comb begin
    nx = st_q;
    if (!st_q.error_seen) begin
      if (is_space) begin
        if (st_q.text_started) begin
          nx.in_trailing_space = 1'b1;
        end
      end else if (st_q.in_trailing_space) begin
        nx.error_seen = 1'b1;
      end else begin
        nx.text_started = 1'b1;
        if (is_digit) begin
          if (st_q.octet_value <= OCTET_MAX) begin
            // times ten as two shifts
            nx.octet_value = (st_q.octet_value << 3) + (st_q.octet_value << 1)
                             + {8'd0, digit};
            nx.have_digit  = 1'b1;
          end else begin
            nx.error_seen = 1'b1;
          end
        end else if (is_dot) begin
          if (st_q.have_digit && st_q.octet_value <= OCTET_MAX
              && st_q.octet_count < LAST_OCTET_INDEX) begin
            nx.partial_address[byte_pos +: 8] =
              st_q.partial_address[byte_pos +: 8] | st_q.octet_value[7:0];
            nx.octet_count = st_q.octet_count + 2'd1;
            nx.octet_value = '0;
            nx.have_digit  = 1'b0;
          end else begin
            nx.error_seen = 1'b1;
          end
        end else begin
          nx.error_seen = 1'b1;
        end
      end
    end
  end

  // result from the updated state
  assign ok = !nx.error_seen && (nx.octet_count == LAST_OCTET_INDEX) && nx.have_digit
              && (nx.octet_value <= OCTET_MAX);
  assign res_valid_o          = fire_i && word_i.is_last;
  assign res_word_o.valid_res = ok;
  assign res_word_o.address   = ok ? {nx.octet_value[7:0], nx.partial_address} : 32'd0;

  // back to the empty state after each string
  always_comb begin
    st_d = st_q;
    if (fire_i) begin
      st_d = word_i.is_last ? parse_state_t'('0) : nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  // state is clear right after a string ends
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && word_i.is_last |=> st_q == parse_state_t'('0))
    else $error("parser state not cleared after last character");

  // error stays set within a string
  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !word_i.is_last && st_q.error_seen |=> st_q.error_seen)
    else $error("error flag dropped inside a string");

  // no octet progress before text has started
  a_no_octets_before_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !st_q.text_started |-> (st_q.octet_count == 2'd0) && !st_q.have_digit)
    else $error("octet progress without text");

  // accumulator never exceeds one digit past a byte
  a_value_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.octet_value <= OCTET_VALUE_MAX)
    else $error("octet accumulator out of range");

endmodule

`default_nettype wire

// ----- rtl/ipv4dq_out_stage.sv -----
// ----------------------------------------------------------------------------
// ipv4dq_out_stage
// Result register: holds a parsed address until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4dq_out_stage (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    load_i,
  input  ipv4dq_pkg::out_word_t  word_i,
  output logic                   free_o,
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output ipv4dq_pkg::out_word_t  out_word_o
);
  import ipv4dq_pkg::*;

  logic      valid_q, valid_d;
  out_word_t word_q, word_d;

  // slot can take a new word when empty or being drained
  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q && out_stall_i;
    word_d  = word_q;
    if (load_i) begin
      valid_d = 1'b1;
      word_d  = word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

`default_nettype wire

// ----- rtl/ipv4_dotted_quad_parser.sv -----
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_parser
// Dotted-decimal IPv4 address parser, one character per word.
// Throughput: one character word per cycle, strings back to back, while the
//   result register is free. The last character is registered in the input
//   stage; when it is taken, the parser update loads the result register.
// Reset: asynchronous, clears the valid flags and the parser state.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_dotted_quad_parser (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  input  ipv4dq_pkg::in_word_t   in_word_i,
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output ipv4dq_pkg::out_word_t  out_word_o
);
  import ipv4dq_pkg::*;

  logic      held_valid;
  in_word_t  held_word;
  logic      take;
  logic      out_free;
  logic      res_valid;
  out_word_t res_word;

  // a last character needs room in the result register
  assign take = held_valid && (!held_word.is_last || out_free);

  ipv4dq_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_word_i    (in_word_i),
    .take_i       (take),
    .held_valid_o (held_valid),
    .held_word_o  (held_word)
  );

  ipv4dq_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (take),
    .word_i      (held_word),
    .res_valid_o (res_valid),
    .res_word_o  (res_word)
  );

  ipv4dq_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .word_i      (res_word),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire
